>>> rtl/core/pker_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pker_pkg
// Shared types and constants of the pad key event block: controller command
// and status bundles, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package pker_pkg;

    // Fixed field widths
    localparam int IDX_W   = 5;
    localparam int DZ_W    = 7;
    localparam int TICK_W  = 8;
    localparam int STICK_W = 8;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 8;

    // Stick centre position
    localparam logic [STICK_W-1:0] STICK_CENTER = 8'd128;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_DEADZONE = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_DELAY    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_RATE     = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_UP       = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_RIGHT    = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_DOWN     = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_LEFT     = 3'd6;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // take the input transaction
        logic scan_step;   // handle the current bit and advance
        logic rpt_step;    // handle the repeat check and commit the word
        logic flush_step;  // move the pending event out as the last one
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_ev;     // current bit changed
        logic rpt_ev;      // a repeat fires on this report
        logic pend_valid;  // an event waits in the pending slot
        logic out_busy;    // output register holds an event not taken now
        logic scan_last;   // current bit is the top bit of the word
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/pker_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pker_ctrl
// Sequencer: accepts a report, walks the bit scan, performs the repeat
// check and flushes the final event, stalling while the output is full.
// ----------------------------------------------------------------------------
module pker_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  pker_pkg::sts_t      sts,
    output pker_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_RPT   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       stall_pend;

    // Stall when a new event needs the pending slot and the output is full
    assign stall_pend = sts.pend_valid && sts.out_busy;
    assign s_ready    = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!(sts.scan_ev && stall_pend)) begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last) begin
                        state_next = ST_RPT;
                    end
                end
            end
            ST_RPT: begin
                if (!(sts.rpt_ev && stall_pend)) begin
                    cmd.rpt_step = 1'b1;
                    state_next   = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (!sts.out_busy) begin
                    cmd.flush_step = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/pker_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pker_dp
// Datapath: configuration registers, stick mapping, previous and current
// button words, bit scan counter, repeat key state, pending event slot and
// output register.
// ----------------------------------------------------------------------------
module pker_dp #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [pker_pkg::CFG_A_W-1:0]    cfg_idx,
    input  wire logic [pker_pkg::CFG_D_W-1:0]    cfg_wdata,
    input  wire logic [31:0]                     s_button_word,
    input  wire logic [pker_pkg::STICK_W-1:0]    s_stick_x,
    input  wire logic [pker_pkg::STICK_W-1:0]    s_stick_y,
    input  wire logic                            s_connected,
    input  pker_pkg::cmd_t                       cmd,
    output pker_pkg::sts_t                       sts,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [pker_pkg::IDX_W-1:0]           m_button_index,
    output logic                                 m_pressed,
    output logic                                 m_last_event
);

    localparam int IW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [IW-1:0] TOP_IDX = IW'(WORD_BITS - 1);

    // Configuration registers
    logic [pker_pkg::DZ_W-1:0]   dz_reg;
    logic [pker_pkg::TICK_W-1:0] delay_reg;
    logic [pker_pkg::TICK_W-1:0] rate_reg;
    logic [pker_pkg::IDX_W-1:0]  up_reg;
    logic [pker_pkg::IDX_W-1:0]  right_reg;
    logic [pker_pkg::IDX_W-1:0]  down_reg;
    logic [pker_pkg::IDX_W-1:0]  left_reg;

    // Report state
    logic [WORD_BITS-1:0] prev_reg, prev_next;
    logic [WORD_BITS-1:0] cur_reg, cur_next;
    logic [WORD_BITS-1:0] chg_reg, chg_next;
    logic [IW-1:0]        scan_reg, scan_next;
    logic                 held_valid_reg, held_valid_next;
    logic [IW-1:0]        held_idx_reg, held_idx_next;
    logic [pker_pkg::TICK_W-1:0] cnt_reg, cnt_next;

    // Event slots
    logic                        pend_valid_reg, pend_valid_next;
    logic [IW-1:0]               pend_idx_reg, pend_idx_next;
    logic                        pend_pressed_reg, pend_pressed_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pker_pkg::IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic                        out_pressed_reg, out_pressed_next;
    logic                        out_last_reg, out_last_next;

    // Combinational terms
    logic [WORD_BITS-1:0] dirs;
    logic [WORD_BITS-1:0] btn;
    logic [WORD_BITS-1:0] stick;
    logic [pker_pkg::STICK_W-1:0] lo_thr;
    logic [pker_pkg::STICK_W-1:0] hi_thr;
    logic go_left, go_right, go_up, go_down;
    logic scan_ev, rpt_ev, new_ev, out_busy;
    logic [IW-1:0] new_idx;
    logic          new_pressed;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg    <= 7'd40;
            delay_reg <= 8'd50;
            rate_reg  <= 8'd10;
            up_reg    <= 5'd4;
            right_reg <= 5'd5;
            down_reg  <= 5'd6;
            left_reg  <= 5'd7;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                pker_pkg::REG_DEADZONE: dz_reg    <= cfg_wdata[pker_pkg::DZ_W-1:0];
                pker_pkg::REG_DELAY:    delay_reg <= cfg_wdata;
                pker_pkg::REG_RATE:     rate_reg  <= cfg_wdata;
                pker_pkg::REG_UP:       up_reg    <= cfg_wdata[pker_pkg::IDX_W-1:0];
                pker_pkg::REG_RIGHT:    right_reg <= cfg_wdata[pker_pkg::IDX_W-1:0];
                pker_pkg::REG_DOWN:     down_reg  <= cfg_wdata[pker_pkg::IDX_W-1:0];
                pker_pkg::REG_LEFT:     left_reg  <= cfg_wdata[pker_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Map the stick outside the deadzone to direction bits
    assign lo_thr   = pker_pkg::STICK_CENTER - {1'b0, dz_reg};
    assign hi_thr   = pker_pkg::STICK_CENTER + {1'b0, dz_reg};
    assign go_left  = (s_stick_x < lo_thr);
    assign go_right = !go_left && (s_stick_x > hi_thr);
    assign go_up    = (s_stick_y < lo_thr);
    assign go_down  = !go_up && (s_stick_y > hi_thr);
    assign btn      = s_button_word[WORD_BITS-1:0];

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            dirs[b]  = (up_reg == 5'(b)) || (right_reg == 5'(b)) ||
                       (down_reg == 5'(b)) || (left_reg == 5'(b));
            stick[b] = (go_up && up_reg == 5'(b)) || (go_right && right_reg == 5'(b)) ||
                       (go_down && down_reg == 5'(b)) || (go_left && left_reg == 5'(b));
        end
    end

    // Event candidates for the scan and the repeat check
    assign scan_ev  = chg_reg[scan_reg];
    assign rpt_ev   = held_valid_reg && cur_reg[held_idx_reg] && (cnt_reg == '0);
    assign out_busy = out_valid_reg && !m_ready;
    assign new_ev   = (cmd.scan_step && scan_ev) || (cmd.rpt_step && rpt_ev);
    assign new_idx     = cmd.rpt_step ? held_idx_reg : scan_reg;
    assign new_pressed = cmd.rpt_step ? 1'b1 : cur_reg[scan_reg];

    assign sts.scan_ev    = scan_ev;
    assign sts.rpt_ev     = rpt_ev;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_busy   = out_busy;
    assign sts.scan_last  = (scan_reg == TOP_IDX);

    // Report state update
    always_comb begin
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        chg_next        = chg_reg;
        scan_next       = scan_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        cnt_next        = cnt_reg;
        if (cmd.load) begin
            scan_next = '0;
            if (s_connected) begin
                cur_next = ((btn & dirs) == '0) ? (btn | stick) : btn;
                chg_next = cur_next ^ prev_reg;
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end else begin
                // Disconnect: release everything held and clear the key state
                cur_next        = '0;
                chg_next        = prev_reg;
                held_valid_next = 1'b0;
                held_idx_next   = '0;
                cnt_next        = '0;
            end
        end
        if (cmd.scan_step) begin
            scan_next = scan_reg + 1'b1;
            if (scan_ev && dirs[scan_reg]) begin
                if (cur_reg[scan_reg]) begin
                    held_valid_next = 1'b1;
                    held_idx_next   = scan_reg;
                    cnt_next        = delay_reg;
                end else if (held_valid_reg && held_idx_reg == scan_reg) begin
                    held_valid_next = 1'b0;
                    held_idx_next   = '0;
                end
            end
        end
        if (cmd.rpt_step) begin
            prev_next = cur_reg;
            if (rpt_ev) begin
                cnt_next = rate_reg;
            end
        end
    end

    // Pending slot and output register
    always_comb begin
        pend_valid_next   = pend_valid_reg;
        pend_idx_next     = pend_idx_reg;
        pend_pressed_next = pend_pressed_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_idx_next      = out_idx_reg;
        out_pressed_next  = out_pressed_reg;
        out_last_next     = out_last_reg;
        // Push the pending event out when a newer one arrives or at the end
        if ((new_ev && pend_valid_reg) || cmd.flush_step) begin
            out_valid_next   = 1'b1;
            out_idx_next     = pker_pkg::IDX_W'(pend_idx_reg);
            out_pressed_next = pend_pressed_reg;
            out_last_next    = cmd.flush_step;
        end
        if (new_ev) begin
            pend_valid_next   = 1'b1;
            pend_idx_next     = new_idx;
            pend_pressed_next = new_pressed;
        end else if (cmd.flush_step) begin
            pend_valid_next = 1'b0;
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            scan_reg       <= '0;
            held_valid_reg <= 1'b0;
            held_idx_reg   <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prev_reg       <= prev_next;
            scan_reg       <= scan_next;
            held_valid_reg <= held_valid_next;
            held_idx_reg   <= held_idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg          <= cur_next;
        chg_reg          <= chg_next;
        pend_idx_reg     <= pend_idx_next;
        pend_pressed_reg <= pend_pressed_next;
        out_idx_reg      <= out_idx_next;
        out_pressed_reg  <= out_pressed_next;
        out_last_reg     <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_button_index = out_idx_reg;
    assign m_pressed      = out_pressed_reg;
    assign m_last_event   = out_last_reg;

endmodule
`default_nettype wire

>>> rtl/core/pad_key_events_with_auto_repeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pad_key_events_with_auto_repeat
// Gamepad report to key press/release events with direction auto repeat.
// ----------------------------------------------------------------------------
// One report is taken per transaction; the block then scans the button word,
// min(BUTTON_BITS, 32) bits wide, one bit per cycle unless an event finds the
// pending slot and the output register both full, and takes no new report
// until the current one is finished. Events leave in ascending bit order
// through an output register, with one event held in a pending slot so that
// the final event of a report can carry last_event; a repeat press of the
// held direction follows the scan. A report that causes no event produces no
// transaction. Configuration must be written through cfg_we, cfg_idx and
// cfg_wdata only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module pad_key_events_with_auto_repeat #(
    parameter int BUTTON_BITS = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [pker_pkg::CFG_A_W-1:0]   cfg_idx,
    input  wire logic [pker_pkg::CFG_D_W-1:0]   cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [31:0]                    s_button_word,
    input  wire logic [pker_pkg::STICK_W-1:0]   s_stick_x,
    input  wire logic [pker_pkg::STICK_W-1:0]   s_stick_y,
    input  wire logic                           s_connected,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [pker_pkg::IDX_W-1:0]          m_button_index,
    output logic                                m_pressed,
    output logic                                m_last_event
);

    // Only the low 32 bits of the button word are ever seen
    localparam int WORD_BITS = (BUTTON_BITS < 32) ? BUTTON_BITS : 32;

    pker_pkg::cmd_t cmd;
    pker_pkg::sts_t sts;

    pker_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pker_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_button_word  (s_button_word),
        .s_stick_x      (s_stick_x),
        .s_stick_y      (s_stick_y),
        .s_connected    (s_connected),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_index (m_button_index),
        .m_pressed      (m_pressed),
        .m_last_event   (m_last_event)
    );

    // Leave idle right after taking a report
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block still idle after accepting a report");

    // No event may be left pending once a report is finished
    a_pend_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.pend_valid)
        else $error("pending event left behind at idle");

    // Controller issues at most one command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.scan_step, cmd.rpt_step, cmd.flush_step}))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire

>>> tb/tb_pad_key_events_with_auto_repeat.sv
// ----------------------------------------------------------------------------
// tb_pad_key_events_with_auto_repeat
// Self-checking bench for the gamepad report to key event block. Drives
// reports on the s_ channel and tracks each accepted report in a scoreboard.
// The scoreboard predicts the press, release and auto repeat events, with the
// stick deadzone and the repeat countdown. Every m_ transaction is checked in
// order against that prediction. The run sweeps several register settings and
// three handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_pad_key_events_with_auto_repeat;
    timeunit 1ns;
    timeprecision 1ps;

    import pker_pkg::*;

    localparam int     CLK_PERIOD    = 8;
    localparam int     RESET_CYCLES  = 11;
    localparam int     SETTLE_CYCLES = 45;       // one full report scan plus margin
    localparam int     PHASE_REPORTS = 62;
    localparam int     NUM_PHASES    = 6;
    localparam int     MAX_SHOWN     = 10;
    localparam int     DRAIN_LIMIT   = 100000;
    localparam longint RUN_LIMIT_NS  = 16_000_000;

    typedef enum int {DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT} pad_dir_e;

    typedef struct {
        bit [IDX_W-1:0] button_index;
        bit             pressed;
        bit             last_event;
    } key_event_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of registers and state, queue of expected events
    // ------------------------------------------------------------------------
    class pad_event_scoreboard;
        bit [DZ_W-1:0]   deadzone    = 7'd40;
        bit [TICK_W-1:0] delay_ticks = 8'd50;
        bit [TICK_W-1:0] rate_ticks  = 8'd10;
        bit [IDX_W-1:0]  up_idx      = 5'd4;
        bit [IDX_W-1:0]  right_idx   = 5'd5;
        bit [IDX_W-1:0]  down_idx    = 5'd6;
        bit [IDX_W-1:0]  left_idx    = 5'd7;

        bit [31:0]       prev_buttons;
        bit              held_valid;
        bit [IDX_W-1:0]  held_idx;
        bit [TICK_W-1:0] countdown;

        key_event_t      report_events[$];
        key_event_t      pending_events[$];
        int              events_checked;
        int              repeat_presses;
        int              failures;

        function void write_reg(bit [CFG_A_W-1:0] idx, bit [CFG_D_W-1:0] val);
            case (idx)
                REG_DEADZONE: deadzone    = val[DZ_W-1:0];
                REG_DELAY:    delay_ticks = val;
                REG_RATE:     rate_ticks  = val;
                REG_UP:       up_idx      = val[IDX_W-1:0];
                REG_RIGHT:    right_idx   = val[IDX_W-1:0];
                REG_DOWN:     down_idx    = val[IDX_W-1:0];
                REG_LEFT:     left_idx    = val[IDX_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] direction_bit(pad_dir_e d);
            case (d)
                DIR_UP:    return 32'd1 << up_idx;
                DIR_RIGHT: return 32'd1 << right_idx;
                DIR_DOWN:  return 32'd1 << down_idx;
                default:   return 32'd1 << left_idx;
            endcase
        endfunction

        function bit [31:0] direction_mask();
            return direction_bit(DIR_UP) | direction_bit(DIR_RIGHT) |
                   direction_bit(DIR_DOWN) | direction_bit(DIR_LEFT);
        endfunction

        function void add_event(int idx, bit pressed);
            key_event_t ev;
            ev.button_index = IDX_W'(idx);
            ev.pressed      = pressed;
            ev.last_event   = 1'b0;
            report_events.push_back(ev);
        endfunction

        // Predict the events of one accepted report and advance the state
        function void note_report(bit [31:0] word, bit [7:0] sx, bit [7:0] sy, bit conn);
            bit [31:0] dirs;
            bit [31:0] buttons;
            bit [31:0] stick;
            bit [31:0] changed;
            int        lo;
            int        hi;
            dirs = direction_mask();
            lo   = 128 - int'(deadzone);
            hi   = 128 + int'(deadzone);
            report_events.delete();
            if (!conn) begin
                // release everything that was down, then forget it all
                for (int i = 0; i < 32; i++)
                    if (prev_buttons[i]) add_event(i, 1'b0);
                prev_buttons = '0;
                held_valid   = 1'b0;
                held_idx     = '0;
                countdown    = '0;
            end else begin
                if (countdown != 0) countdown--;
                buttons = word;
                // stick only counts when no direction button is down
                if ((buttons & dirs) == 0) begin
                    stick = '0;
                    if (int'(sx) < lo)      stick |= direction_bit(DIR_LEFT);
                    else if (int'(sx) > hi) stick |= direction_bit(DIR_RIGHT);
                    if (int'(sy) < lo)      stick |= direction_bit(DIR_UP);
                    else if (int'(sy) > hi) stick |= direction_bit(DIR_DOWN);
                    buttons |= stick;
                end
                changed = buttons ^ prev_buttons;
                for (int i = 0; i < 32; i++) begin
                    if (changed[i]) begin
                        add_event(i, buttons[i]);
                        if (dirs[i]) begin
                            if (buttons[i]) begin
                                held_valid = 1'b1;
                                held_idx   = IDX_W'(i);
                                countdown  = delay_ticks;
                            end else if (held_valid && held_idx == IDX_W'(i)) begin
                                held_valid = 1'b0;
                                held_idx   = '0;
                            end
                        end
                    end
                end
                // repeat press of the held direction
                if (held_valid && buttons[held_idx] && countdown == 0) begin
                    add_event(held_idx, 1'b1);
                    countdown = rate_ticks;
                    repeat_presses++;
                end
                prev_buttons = buttons;
            end
            if (report_events.size() > 0)
                report_events[report_events.size()-1].last_event = 1'b1;
            foreach (report_events[k]) pending_events.push_back(report_events[k]);
        endfunction

        // Compare one result transaction with the oldest expected event
        function void check_event(logic [IDX_W-1:0] idx, logic pressed, logic last);
            key_event_t want;
            events_checked++;
            if (pending_events.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("ERROR: unexpected event index %0d pressed %b last %b",
                             idx, pressed, last);
                return;
            end
            want = pending_events.pop_front();
            if (idx !== want.button_index || pressed !== want.pressed ||
                last !== want.last_event) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display({"ERROR: event %0d: expected index %0d pressed %b last %b,",
                              " got index %0d pressed %b last %b"}, events_checked,
                             want.button_index, want.pressed, want.last_event,
                             idx, pressed, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_A_W-1:0]   cfg_idx;
    logic [CFG_D_W-1:0]   cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [31:0]          s_button_word;
    logic [STICK_W-1:0]   s_stick_x;
    logic [STICK_W-1:0]   s_stick_y;
    logic                 s_connected;
    logic                 m_valid;
    logic                 m_ready;
    logic [IDX_W-1:0]     m_button_index;
    logic                 m_pressed;
    logic                 m_last_event;

    pad_event_scoreboard  key_events;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   reports_sent;
    int                   settings_used;

    pad_key_events_with_auto_repeat DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_word  (s_button_word),
        .s_stick_x      (s_stick_x),
        .s_stick_y      (s_stick_y),
        .s_connected    (s_connected),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_index (m_button_index),
        .m_pressed      (m_pressed),
        .m_last_event   (m_last_event)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            key_events.check_event(m_button_index, m_pressed, m_last_event);
    end

    // ------------------------------------------------------------------------
    // Drive helpers
    // ------------------------------------------------------------------------

    // Stick position on one axis: below, inside or above the deadzone
    function automatic bit [7:0] stick_pos(int side);
        int dz;
        dz = int'(key_events.deadzone);
        if (side < 0)
            return ($urandom_range(0, 3) == 0) ? 8'(127 - dz) : 8'($urandom_range(0, 127 - dz));
        if (side > 0 && dz < 127)
            return ($urandom_range(0, 3) == 0) ? 8'(129 + dz)
                                                : 8'($urandom_range(129 + dz, 255));
        if (side > 0) return 8'd255;
        case ($urandom_range(0, 3))
            0:       return 8'(128 - dz);
            1:       return 8'(128 + dz);
            default: return 8'($urandom_range(128 - dz, 128 + dz));
        endcase
    endfunction

    // Send one report; called and returns at a falling edge, valid left high
    task automatic send_report(bit [31:0] word, bit [7:0] sx, bit [7:0] sy, bit conn);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_button_word <= word;
        s_stick_x     <= sx;
        s_stick_y     <= sy;
        s_connected   <= conn;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        key_events.note_report(word, sx, sy, conn);
        reports_sent++;
        @(negedge aclk);
    endtask

    task automatic write_cfg(bit [CFG_A_W-1:0] idx, bit [CFG_D_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        key_events.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Write all registers; unused upper data bits get random values
    task automatic configure(int dz, int delay, int rate, int up, int right, int down,
                             int left);
        write_cfg(REG_DEADZONE, 8'(dz) | (8'($urandom_range(0, 1)) << 7));
        write_cfg(REG_DELAY, 8'(delay));
        write_cfg(REG_RATE, 8'(rate));
        write_cfg(REG_UP, 8'(up) | (8'($urandom_range(0, 7)) << 5));
        write_cfg(REG_RIGHT, 8'(right) | (8'($urandom_range(0, 7)) << 5));
        write_cfg(REG_DOWN, 8'(down) | (8'($urandom_range(0, 7)) << 5));
        write_cfg(REG_LEFT, 8'(left) | (8'($urandom_range(0, 7)) << 5));
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for all events, then let a report with no event finish
    task automatic wait_block_idle();
        s_valid <= 1'b0;
        while (key_events.pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int        phase_start;
        int        kind;
        int        mode;
        int        xs;
        int        ys;
        int        waited;
        bit [31:0] dirs;
        bit [31:0] word;
        bit [31:0] held;

        key_events    = new();
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_button_word = '0;
        s_stick_x     = STICK_CENTER;
        s_stick_y     = STICK_CENTER;
        s_connected   = 1'b0;
        m_ready       = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 88;
        reports_sent  = 0;
        settings_used = 1;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at reset settings: full word, stick octants, boundaries
        send_report(32'h0000_0000, 8'd128, 8'd128, 1'b1);   // nothing happens
        send_report(32'hFFFF_FFFF, 8'd128, 8'd128, 1'b1);   // every bit pressed
        send_report(32'h0000_0000, 8'd128, 8'd128, 1'b1);   // every bit released
        send_report(32'h0000_0000, 8'd0, 8'd128, 1'b1);     // stick full left
        send_report(32'h0000_0000, 8'd255, 8'd0, 1'b1);     // right and up together
        send_report(32'h0000_0000, 8'd88, 8'd168, 1'b1);    // just inside deadzone
        send_report(32'h0000_0000, 8'd87, 8'd169, 1'b1);    // just outside deadzone
        send_report(32'h0000_0010, 8'd0, 8'd255, 1'b1);     // d-pad wins over stick
        send_report(32'hDEAD_BEEF, 8'd0, 8'd0, 1'b0);       // disconnect releases
        send_report(32'h0000_0000, 8'd128, 8'd128, 1'b0);   // disconnect, nothing down
        send_report(32'h8000_0001, 8'd128, 8'd128, 1'b1);   // lowest and highest bit
        send_report(32'h8000_0001, 8'd168, 8'd88, 1'b1);    // no change
        send_report(32'h0000_0000, 8'd255, 8'd255, 1'b0);

        // Zero delay and rate, right shares up's bit, left at bit 0, down at bit 31
        wait_block_idle();
        configure(0, 0, 0, 3, 3, 31, 0);
        send_report(32'h0000_0008, 8'd128, 8'd128, 1'b1);   // press and repeat at once
        send_report(32'h0000_0008, 8'd128, 8'd128, 1'b1);   // repeat on every report
        send_report(32'h0000_0000, 8'd127, 8'd128, 1'b1);   // stick left one step off
        send_report(32'h0000_0000, 8'd129, 8'd129, 1'b1);   // shared bit plus down
        send_report(32'h8000_0009, 8'd128, 8'd128, 1'b1);   // several directions down
        send_report(32'h0000_0000, 8'd128, 8'd128, 1'b1);
        send_report(32'h7FFF_FFFF, 8'd255, 8'd0, 1'b1);
        send_report(32'h0000_0000, 8'd128, 8'd128, 1'b0);

        // Random phases, each with its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_block_idle();
            case (phase)
                0: configure(0, 0, 0, 0, 1, 2, 3);
                1: configure(127, 255, 255, 31, 30, 29, 28);
                2: configure(10, 3, 1, 9, 9, 20, 31);
                3: configure(64, 1, 2, 4, 5, 6, 7);
                4: configure($urandom_range(0, 127), $urandom_range(0, 6),
                             $urandom_range(0, 4), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 31));
                default: configure(40, 2, 0, $urandom_range(0, 31), $urandom_range(0, 31),
                                   $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            // swap the idling sides from phase 2, then run without idling from phase 4
            if (phase == 2) begin
                send_idle_pct = 88;
                recv_idle_pct = 36;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            dirs        = key_events.direction_mask();
            phase_start = reports_sent;
            while (reports_sent - phase_start < PHASE_REPORTS) begin
                kind = $urandom_range(0, 99);
                if (kind < 60) begin
                    // hold a direction for a while, by d-pad, stick or both
                    mode = $urandom_range(0, 2);
                    word = $urandom & $urandom & $urandom & ~dirs;
                    held = '0;
                    xs   = 0;
                    ys   = 0;
                    if (mode != 1) begin
                        held = key_events.direction_bit(pad_dir_e'($urandom_range(0, 3)));
                        if ($urandom_range(0, 3) == 0)
                            held |= key_events.direction_bit(pad_dir_e'($urandom_range(0, 3)));
                    end
                    if (mode != 0) begin
                        xs = int'($urandom_range(0, 2)) - 1;
                        ys = (xs == 0) ? (($urandom_range(0, 1) == 0) ? -1 : 1)
                                       : int'($urandom_range(0, 2)) - 1;
                    end
                    repeat ($urandom_range(1, 12)) begin
                        if ($urandom_range(0, 5) == 0)
                            word ^= (32'd1 << $urandom_range(0, 31)) & ~dirs;
                        send_report(word | held, stick_pos(xs), stick_pos(ys), 1'b1);
                    end
                end else if (kind < 85) begin
                    // noise: any word, any stick
                    word = $urandom;
                    if ($urandom_range(0, 2) == 0) word &= ~dirs;
                    send_report(word, 8'($urandom), 8'($urandom), 1'b1);
                end else if (kind < 93) begin
                    send_report($urandom, 8'($urandom), 8'($urandom), 1'b0);
                end else begin
                    send_report(32'h0000_0000, stick_pos(0), stick_pos(0), 1'b1);
                end
            end
        end

        // Drain the remaining events
        s_valid <= 1'b0;
        waited = 0;
        while (key_events.pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (key_events.pending_events.size() != 0)
            $display("ERROR: %0d expected events never arrived",
                     key_events.pending_events.size());
        $display("Summary: %0d reports under %0d register settings and three idling patterns,",
                 reports_sent, settings_used);
        $display("         %0d events checked, %0d auto repeat presses, %0d mismatches",
                 key_events.events_checked, key_events.repeat_presses, key_events.failures);
        if (key_events.failures == 0 && key_events.pending_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #(RUN_LIMIT_NS);
        $display("ERROR: run limit reached, block stopped responding");
        $display("== FAIL ==");
        $finish;
    end

endmodule
